[sv/dma4_pkg.sv]
// shared types and register decode constants for the four-channel dma controller
`default_nettype none

package dma4_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CHAN_BITS    = $clog2(NUM_CHANNELS);
   localparam int COUNT_BITS   = 16;
   localparam int ADDR_BITS    = 24;
   localparam int MEM_ADDR_W   = 16;

   // bus functions
   localparam logic [1:0] FUNC_REG_WR  = 2'd0;
   localparam logic [1:0] FUNC_REG_RD  = 2'd1;
   localparam logic [1:0] FUNC_MEM2DEV = 2'd2;
   localparam logic [1:0] FUNC_DEV2MEM = 2'd3;

   // register decode
   localparam logic [9:0] DEC_MASK   = 10'h21c;
   localparam logic [9:0] REG_SELECT = 10'h200;
   localparam logic [9:0] REG_CNT_LO = 10'h004;
   localparam logic [9:0] REG_CNT_HI = 10'h204;
   localparam logic [9:0] REG_ADR_LO = 10'h008;
   localparam logic [9:0] REG_ADR_MD = 10'h208;
   localparam logic [9:0] REG_ADR_HI = 10'h00c;
   localparam logic [9:0] REG_MODE   = 10'h014;
   localparam logic [9:0] REG_MASK   = 10'h21c;

   // mode bits
   localparam int MODE_FROM_MEM_BIT = 3;
   localparam int MODE_AUTOINIT_BIT = 4;
   localparam int MODE_DOWN_BIT     = 5;

   typedef struct packed {
      logic [1:0] func;
      logic [9:0] reg_addr;
      logic [7:0] wdata;
      logic [1:0] chan;
   } dma4_req_type;

   typedef struct packed {
      logic [7:0]            rdata;
      logic                  refused;
      logic                  mem_valid;
      logic                  mem_write;
      logic [MEM_ADDR_W-1:0] mem_addr;
      logic [7:0]            mem_wdata;
      logic                  tc_irq;
   } dma4_rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dma4_cmd_type;

endpackage

`default_nettype wire

[sv/dma4_ctrl.sv]
// sequencing state machine: capture a request, execute it, strobe the result
`default_nettype none

module dma4_ctrl
   import dma4_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   output logic        busy,
   output dma4_cmd_type cmd,
   output logic        rsp_strobe
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy        = (state_ff == ST_EXEC);
   assign cmd.capture = (state_ff == ST_IDLE) && start;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign rsp_strobe  = strobe_ff;

   // an accepted beat is executed next cycle and its result strobed the cycle after
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.execute ##1 rsp_strobe)
      else $error("accepted beat not executed and strobed");

   // result strobe never overlaps execution
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !cmd.execute)
      else $error("strobe during execution");

endmodule

`default_nettype wire

[sv/dma4_datapath.sv]
// channel register file, transfer engine and result register
`default_nettype none

module dma4_datapath
   import dma4_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dma4_cmd_type cmd,
   input  wire dma4_req_type req_data,
   output dma4_rsp_type      rsp_data
);

   dma4_req_type req_ff;
   dma4_rsp_type rsp_ff, rsp_in;

   logic                 base_view_ff, base_view_in;
   logic [CHAN_BITS-1:0] sel_ff, sel_in;
   logic [7:0]           mask_ff, mask_in;
   logic [COUNT_BITS-1:0] cnt_reload_ff [NUM_CHANNELS];
   logic [COUNT_BITS-1:0] cnt_reload_in [NUM_CHANNELS];
   logic [COUNT_BITS:0]   cnt_now_ff    [NUM_CHANNELS];
   logic [COUNT_BITS:0]   cnt_now_in    [NUM_CHANNELS];
   logic [ADDR_BITS-1:0]  adr_reload_ff [NUM_CHANNELS];
   logic [ADDR_BITS-1:0]  adr_reload_in [NUM_CHANNELS];
   logic [ADDR_BITS-1:0]  adr_now_ff    [NUM_CHANNELS];
   logic [ADDR_BITS-1:0]  adr_now_in    [NUM_CHANNELS];
   logic [7:0]            mode_ff       [NUM_CHANNELS];
   logic [7:0]            mode_in       [NUM_CHANNELS];

   logic [CHAN_BITS-1:0]  idx;
   logic [9:0]            dec;
   logic                  both;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic [ADDR_BITS-1:0]  rd_adr;
   logic [COUNT_BITS:0]   cnt_cur;
   logic [ADDR_BITS-1:0]  adr_cur;
   logic [COUNT_BITS-1:0] cnt_rl_cur;
   logic [ADDR_BITS-1:0]  adr_rl_cur;
   logic [7:0]            mode_cur;
   logic [COUNT_BITS:0]   cnt_dec;
   logic                  to_mem;
   logic                  chan_masked;

   // single read port into the channel file: transfer channel or selected channel
   assign idx        = req_ff.func[1] ? req_ff.chan : sel_ff;
   assign dec        = req_ff.reg_addr & DEC_MASK;
   assign both       = !base_view_ff;
   assign cnt_cur    = cnt_now_ff[idx];
   assign adr_cur    = adr_now_ff[idx];
   assign cnt_rl_cur = cnt_reload_ff[idx];
   assign adr_rl_cur = adr_reload_ff[idx];
   assign mode_cur   = mode_ff[idx];
   assign rd_cnt     = both ? cnt_cur[COUNT_BITS-1:0] : cnt_rl_cur;
   assign rd_adr     = both ? adr_cur : adr_rl_cur;
   assign cnt_dec    = cnt_cur - {{COUNT_BITS{1'b0}}, 1'b1};
   assign to_mem     = (req_ff.func == FUNC_DEV2MEM);
   assign chan_masked = mask_ff[{1'b0, req_ff.chan}];

   always_comb begin
      base_view_in  = base_view_ff;
      sel_in        = sel_ff;
      mask_in       = mask_ff;
      cnt_reload_in = cnt_reload_ff;
      cnt_now_in    = cnt_now_ff;
      adr_reload_in = adr_reload_ff;
      adr_now_in    = adr_now_ff;
      mode_in       = mode_ff;
      rsp_in        = '0;
      case (req_ff.func)
         FUNC_REG_WR: begin
            case (dec)
               REG_SELECT: begin
                  base_view_in = req_ff.wdata[2];
                  sel_in       = req_ff.wdata[CHAN_BITS-1:0];
               end
               REG_CNT_LO: begin
                  cnt_reload_in[idx][7:0] = req_ff.wdata;
                  if (both) cnt_now_in[idx] = {1'b0, cnt_cur[15:8], req_ff.wdata};
               end
               REG_CNT_HI: begin
                  cnt_reload_in[idx][15:8] = req_ff.wdata;
                  if (both) cnt_now_in[idx] = {1'b0, req_ff.wdata, cnt_cur[7:0]};
               end
               REG_ADR_LO: begin
                  adr_reload_in[idx][7:0] = req_ff.wdata;
                  if (both) adr_now_in[idx][7:0] = req_ff.wdata;
               end
               REG_ADR_MD: begin
                  adr_reload_in[idx][15:8] = req_ff.wdata;
                  if (both) adr_now_in[idx][15:8] = req_ff.wdata;
               end
               REG_ADR_HI: begin
                  adr_reload_in[idx][23:16] = req_ff.wdata;
                  if (both) adr_now_in[idx][23:16] = req_ff.wdata;
               end
               REG_MODE: mode_in[idx] = req_ff.wdata;
               REG_MASK: mask_in = req_ff.wdata;
               default: ;
            endcase
         end
         FUNC_REG_RD: begin
            case (dec)
               REG_SELECT: rsp_in.rdata = {5'd0, base_view_ff, sel_ff};
               REG_CNT_LO: rsp_in.rdata = rd_cnt[7:0];
               REG_CNT_HI: rsp_in.rdata = rd_cnt[15:8];
               REG_ADR_LO: rsp_in.rdata = rd_adr[7:0];
               REG_ADR_MD: rsp_in.rdata = rd_adr[15:8];
               REG_ADR_HI: rsp_in.rdata = rd_adr[23:16];
               REG_MODE:   rsp_in.rdata = mode_cur;
               REG_MASK:   rsp_in.rdata = mask_ff;
               default:    rsp_in.rdata = 8'd0;
            endcase
         end
         default: begin
            if (chan_masked || (mode_cur[MODE_FROM_MEM_BIT] == to_mem)) begin
               rsp_in.refused = 1'b1;
            end else begin
               rsp_in.mem_valid = 1'b1;
               rsp_in.mem_write = to_mem;
               rsp_in.mem_addr  = adr_cur[MEM_ADDR_W-1:0];
               rsp_in.mem_wdata = to_mem ? req_ff.wdata : 8'd0;
               if (mode_cur[MODE_DOWN_BIT])
                  adr_now_in[idx] = adr_cur - {{(ADDR_BITS-1){1'b0}}, 1'b1};
               else
                  adr_now_in[idx] = adr_cur + {{(ADDR_BITS-1){1'b0}}, 1'b1};
               cnt_now_in[idx] = cnt_dec;
               // count underflow: reload or terminal count
               if (cnt_dec[COUNT_BITS]) begin
                  if (mode_cur[MODE_AUTOINIT_BIT]) begin
                     adr_now_in[idx] = adr_rl_cur;
                     cnt_now_in[idx] = {1'b0, cnt_rl_cur};
                  end else begin
                     rsp_in.tc_irq = 1'b1;
                     mask_in[{1'b0, req_ff.chan}] = 1'b1;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_view_ff <= 1'b0;
         sel_ff       <= '0;
         mask_ff      <= '0;
         rsp_ff       <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            cnt_reload_ff[i] <= '0;
            cnt_now_ff[i]    <= '0;
            adr_reload_ff[i] <= '0;
            adr_now_ff[i]    <= '0;
            mode_ff[i]       <= '0;
         end
      end else if (cmd.execute) begin
         base_view_ff  <= base_view_in;
         sel_ff        <= sel_in;
         mask_ff       <= mask_in;
         rsp_ff        <= rsp_in;
         cnt_reload_ff <= cnt_reload_in;
         cnt_now_ff    <= cnt_now_in;
         adr_reload_ff <= adr_reload_in;
         adr_now_ff    <= adr_now_in;
         mode_ff       <= mode_in;
      end
   end

   assign rsp_data = rsp_ff;

   // a refused transfer issues no memory access
   a_refused_no_access: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.refused |-> !rsp_ff.mem_valid)
      else $error("refused transfer issued an access");

   // terminal count only with an issued access, and the channel is masked after it
   a_tc_masks: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && rsp_in.tc_irq) |=> (rsp_ff.mem_valid && mask_ff[{1'b0, req_ff.chan}]))
      else $error("terminal count without access or mask");

endmodule

`default_nettype wire

[sv/four_channel_dma_controller.sv]
// four-channel dma controller top level: controller plus channel datapath
// a beat is captured, executed in the exec state, then strobed from the result register
// no new beat is accepted while busy; busy is high for the execute cycle only
// every beat gives exactly one result, shown for one cycle; the receiver cannot stall
// reset (synchronous, active high) clears all channel registers, mask, select and view
// the next beat may be accepted in the same cycle the previous result is strobed
`default_nettype none

module four_channel_dma_controller
   import dma4_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire dma4_req_type req_data,
   output logic              rsp_strobe,
   output dma4_rsp_type      rsp_data
);

   dma4_cmd_type cmd;

   dma4_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   dma4_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
